/* rtl/mtrg_pkg.sv */
// Package with the constants, codes and tempering function of the MT19937 range generator.
package mtrg_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned ADDR_W       = 10;

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] WORDS_ADDR = ADDR_W'(STATE_WORDS);
	localparam logic [ADDR_W:0]   OFFSET_W   = (ADDR_W+1)'(TWIST_OFFSET);
	localparam logic [ADDR_W:0]   WORDS_W    = (ADDR_W+1)'(STATE_WORDS);

	localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
	localparam logic [31:0] MASK_B    = 32'h9d2c5680;
	localparam logic [31:0] MASK_C    = 32'hefc60000;
	localparam logic [31:0] UPPER     = 32'h80000000;
	localparam logic [31:0] MIX_K1    = 32'd1664525;
	localparam logic [31:0] MIX_K2    = 32'd1566083941;

	typedef enum logic [1:0] {
		REQ_RESEED = 2'd0,
		REQ_RAW    = 2'd1,
		REQ_RANGE  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	localparam logic [2:0] CFG_SEED_A = 3'd0;
	localparam logic [2:0] CFG_SEED_B = 3'd1;
	localparam logic [2:0] CFG_SEED_C = 3'd2;
	localparam logic [2:0] CFG_SEED_D = 3'd3;
	localparam logic [2:0] CFG_COUNT  = 3'd4;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MASK_B);
		y = y ^ ((y << 15) & MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* rtl/mt19937_range_generator.sv */
// A raw draw reads and tempers the next word; once per 624 draws the store is twisted first.
// A ranged draw of nonzero span adds a remainder step, plus one for the limit if span <= 2^31.
// Reseed clears the 624-word store, then mixes the seeds into it.
// One item in flight; the next is taken once the result sits in the output register.
// After reset the store is cleared, one word a cycle, before items are taken.
module mt19937_range_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mtrg_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DRAW_CHK, S_DRAW_RD, S_TW_LOAD, S_TW_A, S_TW_B, S_TW_C,
		S_R_LEFT, S_R_MOD, S_MX_A, S_MX_B, S_MX_W0, S_PHASE_END, S_FINISH
	} state_t;

	state_t state_q;
	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rdata_q;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [31:0] wdata;
	logic we;

	logic [31:0] seed_q [4];
	logic [2:0]  seed_count_q;
	logic        reseed_q, phase1_q, out_valid_q;
	logic [1:0]  req_q, j_q;
	logic [31:0] begin_q, dist_q, maxv_q, res_q, value_q;
	logic [31:0] cur_q, nxt_q, prev_q, mul_q;
	logic [ADDR_W-1:0] idx_q, kk_q, i_q, k_q;

	logic [ADDR_W-1:0] nx, far;
	logic [ADDR_W:0]   far_sum;
	logic [31:0] dist_in, y_tw, twv, y_tmp, newv, pm, left;
	logic [31:0] prod;
	logic [2:0]  len;
	logic        rem_start, rem_done, out_free;
	logic [31:0] rem_a, rem_d, rem_r;

	mtrg_rem u_rem (
		.clk(clk), .arst_n(arst_n), .start(rem_start), .dividend(rem_a),
		.divisor(rem_d), .done(rem_done), .rem(rem_r)
	);

	assign dist_in  = range_end - range_begin;
	assign nx       = (kk_q == LAST_ADDR) ? '0 : kk_q + 1'b1;
	assign far_sum  = {1'b0, kk_q} + OFFSET_W;
	assign far      = (far_sum >= WORDS_W) ? ADDR_W'(far_sum - WORDS_W) : far_sum[ADDR_W-1:0];
	assign y_tw     = {cur_q[31], nxt_q[30:0]};
	assign twv      = rdata_q ^ (y_tw >> 1) ^ (y_tw[0] ? TWIST_XOR : 32'd0);
	assign y_tmp    = temper(rdata_q);
	assign pm       = prev_q ^ (prev_q >> 30);
	assign prod     = pm * (phase1_q ? MIX_K1 : MIX_K2);
	assign len      = (seed_count_q == 3'd0) ? 3'd1 : (seed_count_q > 3'd4) ? 3'd4 : seed_count_q;
	assign newv     = phase1_q ? ((rdata_q ^ mul_q) + seed_q[j_q] + {30'd0, j_q})
	                           : ((rdata_q ^ mul_q) - {22'd0, i_q});
	assign left     = {rem_r[30:0], 1'b0};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		raddr = i_q;
		we    = 1'b0;
		waddr = kk_q;
		wdata = '0;
		unique case (state_q)
			S_CLEAR:     we = 1'b1;
			S_DRAW_CHK:  raddr = (idx_q >= WORDS_ADDR) ? '0 : idx_q;
			S_TW_A:      raddr = nx;
			S_TW_B:      raddr = far;
			S_TW_C: begin
				we    = 1'b1;
				wdata = twv;
			end
			S_MX_B: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = newv;
			end
			S_MX_W0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = prev_q;
			end
			S_PHASE_END: begin
				we    = !phase1_q;
				waddr = '0;
				wdata = UPPER;
			end
			default: ;
		endcase
	end

	always_comb begin
		rem_start = 1'b0;
		rem_a     = UPPER;
		rem_d     = dist_q;
		if (state_q == S_IDLE) begin
			rem_d     = dist_in;
			rem_start = in_valid && (req_t'(req_type) == REQ_RANGE) &&
			            (dist_in != 32'd0) && (dist_in <= UPPER);
		end else if (state_q == S_DRAW_RD) begin
			rem_a     = y_tmp;
			rem_start = (req_t'(req_q) == REQ_RANGE) && (y_tmp <= maxv_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			kk_q         <= '0;
			idx_q        <= WORDS_ADDR;
			reseed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			seed_q       <= '{default: '0};
			seed_count_q <= 3'd1;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SEED_A: seed_q[0] <= cfg_data;
					CFG_SEED_B: seed_q[1] <= cfg_data;
					CFG_SEED_C: seed_q[2] <= cfg_data;
					CFG_SEED_D: seed_q[3] <= cfg_data;
					CFG_COUNT:  seed_count_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					kk_q <= kk_q + 1'b1;
					if (kk_q == LAST_ADDR) begin
						state_q <= reseed_q ? S_MX_A : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						begin_q <= range_begin;
						dist_q  <= dist_in;
						maxv_q  <= dist_in - 32'd1;
						unique case (req_t'(req_type))
							REQ_RESEED: begin
								reseed_q <= 1'b1;
								kk_q     <= '0;
								i_q      <= ADDR_W'(1);
								j_q      <= '0;
								k_q      <= WORDS_ADDR;
								prev_q   <= '0;
								phase1_q <= 1'b1;
								state_q  <= S_CLEAR;
							end
							REQ_RAW: state_q <= S_DRAW_CHK;
							REQ_RANGE: begin
								if (dist_in == 32'd0) begin
									res_q   <= range_begin;
									state_q <= S_FINISH;
								end else if (dist_in <= UPPER) begin
									state_q <= S_R_LEFT;
								end else begin
									state_q <= S_DRAW_CHK;
								end
							end
							REQ_NONE: begin
								res_q   <= '0;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_R_LEFT: begin
					if (rem_done) begin
						maxv_q  <= (left >= dist_q) ? ~(left - dist_q) : ~left;
						state_q <= S_DRAW_CHK;
					end
				end
				S_DRAW_CHK: begin
					if (idx_q >= WORDS_ADDR) begin
						kk_q    <= '0;
						state_q <= S_TW_LOAD;
					end else begin
						state_q <= S_DRAW_RD;
					end
				end
				S_TW_LOAD: begin
					cur_q   <= rdata_q;
					state_q <= S_TW_A;
				end
				S_TW_A: state_q <= S_TW_B;
				S_TW_B: begin
					nxt_q   <= rdata_q;
					state_q <= S_TW_C;
				end
				S_TW_C: begin
					cur_q <= nxt_q;
					if (kk_q == LAST_ADDR) begin
						idx_q   <= '0;
						state_q <= S_DRAW_CHK;
					end else begin
						kk_q    <= kk_q + 1'b1;
						state_q <= S_TW_A;
					end
				end
				S_DRAW_RD: begin
					idx_q <= idx_q + 1'b1;
					if (req_t'(req_q) != REQ_RANGE) begin
						res_q   <= y_tmp;
						state_q <= S_FINISH;
					end else if (y_tmp > maxv_q) begin
						state_q <= S_DRAW_CHK;
					end else begin
						state_q <= S_R_MOD;
					end
				end
				S_R_MOD: begin
					if (rem_done) begin
						res_q   <= begin_q + rem_r;
						state_q <= S_FINISH;
					end
				end
				S_MX_A: begin
					mul_q   <= prod;
					state_q <= S_MX_B;
				end
				S_MX_B: begin
					prev_q <= newv;
					k_q    <= k_q - 1'b1;
					if (phase1_q) begin
						j_q <= ({1'b0, j_q} + 3'd1 >= len) ? 2'd0 : j_q + 2'd1;
					end
					if (i_q == LAST_ADDR) begin
						i_q     <= ADDR_W'(1);
						state_q <= S_MX_W0;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= (k_q == ADDR_W'(1)) ? S_PHASE_END : S_MX_A;
					end
				end
				S_MX_W0: state_q <= (k_q == '0) ? S_PHASE_END : S_MX_A;
				S_PHASE_END: begin
					if (phase1_q) begin
						phase1_q <= 1'b0;
						k_q      <= LAST_ADDR;
						state_q  <= S_MX_A;
					end else begin
						reseed_q <= 1'b0;
						idx_q    <= WORDS_ADDR;
						res_q    <= '0;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						value_q     <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign cfg_ready = 1'b1;
endmodule

/* rtl/mtrg_rem.sv */
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module mtrg_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);
	logic [31:0] a_q;
	logic [31:0] d_q;
	logic [31:0] r_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {r_q, a_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				a_q    <= dividend;
				d_q    <= divisor;
				r_q    <= '0;
			end else if (busy_q) begin
				a_q <= {a_q[30:0], 1'b0};
				if (trial >= {1'b0, d_q}) begin
					r_q <= 32'(trial - {1'b0, d_q});
				end else begin
					r_q <= trial[31:0];
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

/* rtl/mtrg_checker.sv */
// Port-level assertions for the MT19937 range generator and their binding.
module mtrg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("stalled result changed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("input taken before the store was cleared");
endmodule

bind mt19937_range_generator mtrg_checker u_mtrg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .value(value)
);

/* bench/mt19937_range_generator_checker.sv */
// Checker for the MT19937 range generator: predicts every value and compares it with the block.
module mt19937_range_generator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	import mtrg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] twister[STATE_WORDS];
	int unsigned word_pos;
	logic [31:0] seed_word[4];
	logic [2:0]  seed_len;
	logic [31:0] expected_values[$];

	function automatic void mix_seeds();
		int unsigned len, i, j, k;
		logic [31:0] p, m;
		len = (seed_len < 1) ? 1 : (seed_len > 4) ? 4 : seed_len;
		i = 1;
		j = 0;
		foreach (twister[n]) twister[n] = '0;
		for (k = STATE_WORDS; k > 0; k--) begin
			p = twister[i-1];
			m = (p ^ (p >> 30)) * MIX_K1;
			twister[i] = (twister[i] ^ m) + seed_word[j & 3] + 32'(j);
			i++;
			j++;
			if (i >= STATE_WORDS) begin
				twister[0] = twister[STATE_WORDS-1];
				i = 1;
			end
			if (j >= len) j = 0;
		end
		for (k = STATE_WORDS - 1; k > 0; k--) begin
			p = twister[i-1];
			m = (p ^ (p >> 30)) * MIX_K2;
			twister[i] = (twister[i] ^ m) - 32'(i);
			i++;
			if (i >= STATE_WORDS) begin
				twister[0] = twister[STATE_WORDS-1];
				i = 1;
			end
		end
		twister[0] = UPPER;
		word_pos = STATE_WORDS;
	endfunction

	function automatic logic [31:0] next_tempered();
		logic [31:0] y;
		if (word_pos >= STATE_WORDS) begin
			for (int kk = 0; kk < STATE_WORDS; kk++) begin
				y = (twister[kk] & UPPER) | (twister[(kk+1) % STATE_WORDS] & ~UPPER);
				twister[kk] = twister[(kk + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
					^ (y[0] ? TWIST_XOR : 32'd0);
			end
			word_pos = 0;
		end
		y = twister[word_pos];
		word_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MASK_B);
		y = y ^ ((y << 15) & MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] draw_in_range(logic [31:0] lo, logic [31:0] hi);
		logic [31:0] span, limit, left, r;
		span = hi - lo;
		if (span == 0) return lo;
		if (span <= UPPER) begin
			left = (UPPER % span) * 2;
			if (left >= span) left = left - span;
			limit = ~left;
		end else begin
			limit = span - 1;
		end
		do r = next_tempered(); while (r > limit);
		return lo + (r % span);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (twister[n]) twister[n] = '0;
			word_pos = STATE_WORDS;
			foreach (seed_word[n]) seed_word[n] = '0;
			seed_len = 3'd1;
			expected_values.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SEED_A: seed_word[0] = cfg_data;
					CFG_SEED_B: seed_word[1] = cfg_data;
					CFG_SEED_C: seed_word[2] = cfg_data;
					CFG_SEED_D: seed_word[3] = cfg_data;
					CFG_COUNT:  seed_len = cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (req_t'(req_type))
					REQ_RESEED: begin
						mix_seeds();
						expected_values.push_back(32'd0);
					end
					REQ_RAW:   expected_values.push_back(next_tempered());
					REQ_RANGE: expected_values.push_back(draw_in_range(range_begin, range_end));
					default:   expected_values.push_back(32'd0);
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$display("%0t: unexpected value %h", $time, value);
					errors++;
				end else begin
					if (value !== expected_values[0]) begin
						$display("%0t: value expected %h actual %h", $time,
							expected_values[0], value);
						errors++;
					end
					void'(expected_values.pop_front());
				end
			end
		end
		pending = expected_values.size();
	end
endmodule

/* bench/mt19937_range_generator_test.sv */
// Top of the MT19937 range generator testbench: clock, reset, stimulus and verdict.
module mt19937_range_generator_test;
	import mtrg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic [31:0] range_begin = '0;
	logic [31:0] range_end = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_SEED_A;
	logic [31:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          burst_left = 0;
	logic [11:0] stall_phase = '0;

	mt19937_range_generator DUT (.*);

	mt19937_range_generator_checker checker_inst (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("mt19937_range_generator_test: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_phase[11:10])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= 1'($urandom_range(0, 1));
			2'd2: out_stall <= (stall_phase[2:0] != 3'd0);
			default: out_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	task automatic send_request(req_t kind, logic [31:0] lo, logic [31:0] hi);
		in_valid <= 1'b1;
		req_type <= kind;
		range_begin <= lo;
		range_end <= hi;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_one(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic write_settings(logic [31:0] a, logic [31:0] b, logic [31:0] c,
		logic [31:0] d, logic [2:0] count);
		write_one(CFG_SEED_A, a);
		write_one(CFG_SEED_B, b);
		write_one(CFG_SEED_C, c);
		write_one(CFG_SEED_D, d);
		write_one(CFG_COUNT, count);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_span();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20);
			1: return 32'h80000000 + $urandom_range(0, 3) - 2;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return 32'hffffffff - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] lo;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_RAW, '0, '0);
		send_request(REQ_RANGE, 32'd5, 32'd9);
		send_request(REQ_NONE, 32'hffffffff, 32'hffffffff);
		send_request(REQ_RESEED, '0, '0);
		send_request(REQ_RAW, '0, '0);
		send_request(REQ_RANGE, 32'hffffffff, 32'hffffffff);
		send_request(REQ_RANGE, 32'd0, 32'd1);
		send_request(REQ_RANGE, 32'd0, 32'hffffffff);
		send_request(REQ_RANGE, 32'd0, 32'h80000000);
		send_request(REQ_RANGE, 32'd7, 32'h80000008);
		send_request(REQ_RANGE, 32'hffffffff, 32'd5);
		send_request(REQ_RANGE, 32'd100, 32'd103);
		wait_drained();
		write_settings('1, '1, '1, '1, 3'd7);
		send_request(REQ_RESEED, '0, '0);
		send_request(REQ_RAW, '0, '0);
		send_request(REQ_RANGE, 32'h12345678, 32'h12345677);
		wait_drained();
		write_settings(32'h0123, 32'h0234, 32'h0345, 32'h0456, 3'd0);
		send_request(REQ_RESEED, '0, '0);
		send_request(REQ_RAW, '0, '0);
		send_request(REQ_NONE, '0, '0);
		wait_drained();
		write_settings(32'h0123, 32'h0234, 32'h0345, 32'h0456, 3'd4);
		send_request(REQ_RESEED, '0, '0);
		send_request(REQ_RAW, '0, '0);

		for (int n = 0; n < 1600; n++) begin
			if (n % 400 == 200) begin
				wait_drained();
				write_settings($urandom, $urandom, $urandom, $urandom,
					3'($urandom_range(0, 7)));
				send_request(REQ_RESEED, '0, '0);
			end
			case ($urandom_range(0, 99))
				0, 1: send_request(REQ_RESEED, $urandom, $urandom);
				2, 3, 4: send_request(REQ_NONE, $urandom, $urandom);
				5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22,
				23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39,
				40, 41, 42, 43, 44, 45, 46, 47, 48, 49:
					send_request(REQ_RAW, $urandom, $urandom);
				default: begin
					lo = $urandom;
					send_request(REQ_RANGE, lo, lo + pick_span());
				end
			endcase
		end
		wait_drained();

		if (errors == 0 && pending == 0) begin
			$display("mt19937_range_generator_test: PASS");
		end else begin
			$display("mt19937_range_generator_test: FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/mtrg_pkg.sv
rtl/mtrg_rem.sv
rtl/mt19937_range_generator.sv
rtl/mtrg_checker.sv
bench/mt19937_range_generator_checker.sv
bench/mt19937_range_generator_test.sv
